// File: sv/mono_framebuffer_line_circle_drawer_top_defines.svh
// Assertion macros shared by the checker.
`ifndef MONO_FRAMEBUFFER_LINE_CIRCLE_DRAWER_TOP_DEFINES_SVH
`define MONO_FRAMEBUFFER_LINE_CIRCLE_DRAWER_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define MFB_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define MFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/mfb_pkg.sv
`default_nettype none
package mfb_pkg;
	localparam int DisplayWidthDef = 128;
	localparam int DisplayPagesDef = 8;

	typedef enum logic [2:0] {
		CMD_CLEAR = 3'd0,
		CMD_PIXEL = 3'd1,
		CMD_LINE  = 3'd2,
		CMD_CIRC  = 3'd3,
		CMD_RECT  = 3'd4,
		CMD_READ  = 3'd5,
		CMD_NOP6  = 3'd6,
		CMD_NOP7  = 3'd7
	} cmd_t;

	typedef struct packed {
		logic [2:0] command;
		logic [7:0] x0;
		logic [7:0] y0;
		logic [7:0] x1;
		logic [7:0] y1;
		logic [7:0] radius;
		logic [7:0] width;
		logic [7:0] height;
		logic       color;
		logic [2:0] read_page;
		logic [6:0] read_column;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       is_read;
	} res_item_t;
endpackage
`default_nettype wire

// File: sv/mfb_if.sv
`default_nettype none
interface mfb_cmd_if import mfb_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mfb_res_if import mfb_pkg::*; ();
	logic      valid;
	logic      ready;
	res_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/mfb_ram.sv
`default_nettype none
module mfb_ram #(
	parameter int Width = 8,
	parameter int Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: sv/mfb_front.sv
`default_nettype none
// Accept items into a two-entry queue; the back end pops one at a time.
module mfb_front import mfb_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	mfb_cmd_if.sink        cmd,
	output logic           q_valid,
	output cmd_item_t      q_item,
	input  wire logic      q_pop
);
	cmd_item_t  buf_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;

	assign cmd.ready = (cnt_q != 2'd2);
	assign push      = cmd.valid && cmd.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign q_item    = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= cmd.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule
`default_nettype wire

// File: sv/mfb_back.sv
`default_nettype none
// Rasterizer: generate pixels, read-modify-write the frame byte per pixel; also clear the frame and read bytes.
module mfb_back import mfb_pkg::*; #(
	parameter int DisplayWidth = DisplayWidthDef,
	parameter int DisplayPages = DisplayPagesDef
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      q_valid,
	input  wire cmd_item_t q_item,
	output logic           q_pop,
	mfb_res_if.source      res
);
	localparam int Depth = DisplayWidth * DisplayPages;
	localparam int Aw    = $clog2(Depth);
	localparam int Rows  = DisplayPages * 8;

	typedef enum logic [3:0] {
		S_IDLE, S_WIPE, S_LSETUP, S_LINE, S_CIRC, S_PIX, S_RD, S_WR, S_RDATA, S_DONE
	} state_t;

	state_t            state_q, ret_q;
	cmd_item_t         it_q;
	logic [Aw:0]       wipe_q;
	logic              res_v_q;
	res_item_t         res_q;
	// line engine
	logic [7:0]        lax_q, lay_q, lbx_q, lby_q;
	logic              steep_q;
	logic [8:0]        lx_q, lend_q;
	logic [7:0]        ly_q;
	logic signed [9:0] err_q;
	logic [8:0]        ldx_q, ldy_q;
	logic              yneg_q;
	logic [1:0]        edge_q;
	// circle engine
	logic signed [10:0] f_q, ddy_q;
	logic [10:0]        ddx_q;
	logic [7:0]         cx_q, cy_q;
	logic [2:0]         oct_q;
	// pixel
	logic [7:0]         px_q, py_q;
	logic [Aw-1:0]      addr_q;
	logic [2:0]         bit_q;
	logic               we;
	logic [Aw-1:0]      waddr;
	logic [7:0]         wdata, rdata;
	logic [Aw-1:0]      raddr;

	mfb_ram #(.Width(8), .Depth(Depth)) u_ram (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);

	assign res.valid = res_v_q;
	assign res.data  = res_q;
	assign raddr     = addr_q;

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = rdata;
		if (state_q == S_WIPE) begin
			we    = 1'b1;
			waddr = wipe_q[Aw-1:0];
			wdata = 8'd0;
		end else if (state_q == S_WR) begin
			we = 1'b1;
			wdata[bit_q] = it_q.color;
		end
	end

	// Line endpoints for rectangle edge k.
	function automatic logic [31:0] rect_edge(input cmd_item_t c, input logic [1:0] k);
		logic [7:0] r, b;
		r = c.x0 + c.width - 8'd1;
		b = c.y0 + c.height - 8'd1;
		unique case (k)
			2'd0:    rect_edge = {c.x0, c.y0, r, c.y0};
			2'd1:    rect_edge = {c.x0, b, r, b};
			2'd2:    rect_edge = {c.x0, c.y0, c.x0, b};
			default: rect_edge = {r, c.y0, r, b};
		endcase
	endfunction

	logic [8:0] adx, ady;
	logic       stp;
	logic [7:0] sax, say, sbx, sby;
	always_comb begin
		adx = (lbx_q >= lax_q) ? {1'b0, lbx_q - lax_q} : {1'b0, lax_q - lbx_q};
		ady = (lby_q >= lay_q) ? {1'b0, lby_q - lay_q} : {1'b0, lay_q - lby_q};
		stp = ady > adx;
		sax = stp ? lay_q : lax_q;
		say = stp ? lax_q : lay_q;
		sbx = stp ? lby_q : lbx_q;
		sby = stp ? lbx_q : lby_q;
		if (sax > sbx) begin
			{sax, sbx} = {sbx, sax};
			{say, sby} = {sby, say};
		end
	end

	// Circle octant pixel offsets; x = lx_q, y = ly_q reused.
	logic [7:0] cpx, cpy, cxx, cyy;
	always_comb begin
		cxx = lx_q[7:0];
		cyy = ly_q;
		unique case (oct_q)
			3'd0: begin cpx = cx_q + cxx; cpy = cy_q + cyy; end
			3'd1: begin cpx = cx_q - cxx; cpy = cy_q + cyy; end
			3'd2: begin cpx = cx_q + cxx; cpy = cy_q - cyy; end
			3'd3: begin cpx = cx_q - cxx; cpy = cy_q - cyy; end
			3'd4: begin cpx = cx_q + cyy; cpy = cy_q + cxx; end
			3'd5: begin cpx = cx_q - cyy; cpy = cy_q + cxx; end
			3'd6: begin cpx = cx_q + cyy; cpy = cy_q - cxx; end
			default: begin cpx = cx_q - cyy; cpy = cy_q - cxx; end
		endcase
	end

	logic signed [10:0] f_n, ddy_n;
	logic [7:0]         cy_n;
	logic [10:0]        ddx_n;
	always_comb begin
		f_n   = f_q;
		ddy_n = ddy_q;
		cy_n  = ly_q;
		if (f_q >= 0) begin
			cy_n  = ly_q - 8'd1;
			ddy_n = ddy_q + 11'sd2;
			f_n   = f_q + ddy_q + 11'sd2;
		end
		ddx_n = ddx_q + 11'd2;
		f_n   = f_n + $signed(ddx_n);
	end

	assign q_pop = (state_q == S_IDLE) && q_valid && !res_v_q;

	always_ff @(posedge clk) begin
		if (state_q == S_PIX) begin
			addr_q <= Aw'({24'd0, px_q} + {24'd0, 3'd0, py_q[7:3]} * DisplayWidth);
			bit_q  <= py_q[2:0];
		end else if (state_q == S_IDLE && q_pop) begin
			addr_q <= Aw'({25'd0, q_item.read_column} +
				{29'd0, q_item.read_page} * DisplayWidth);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WIPE;
			ret_q   <= S_IDLE;
			wipe_q  <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (res_v_q && res.ready) res_v_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						it_q   <= q_item;
						res_q  <= '0;
						edge_q <= 2'd0;
						unique case (cmd_t'(q_item.command))
							CMD_CLEAR: begin
								wipe_q <= '0; ret_q <= S_DONE; state_q <= S_WIPE;
							end
							CMD_PIXEL: begin
								px_q <= q_item.x0; py_q <= q_item.y0;
								ret_q <= S_DONE; state_q <= S_PIX;
							end
							CMD_LINE: begin
								{lax_q, lay_q, lbx_q, lby_q} <=
									{q_item.x0, q_item.y0, q_item.x1, q_item.y1};
								state_q <= S_LSETUP;
							end
							CMD_RECT: begin
								{lax_q, lay_q, lbx_q, lby_q} <= rect_edge(q_item, 2'd0);
								state_q <= S_LSETUP;
							end
							CMD_CIRC: begin
								cx_q <= q_item.x0; cy_q <= q_item.y0;
								lx_q <= 9'd0; ly_q <= q_item.radius;
								f_q <= 11'sd1 - $signed({3'd0, q_item.radius});
								ddx_q <= 11'd1;
								ddy_q <= -$signed({2'd0, q_item.radius, 1'b0});
								oct_q <= 3'd0;
								state_q <= S_CIRC;
							end
							CMD_READ: begin
								res_q.is_read <= 1'b1;
								state_q <= (q_item.read_page < DisplayPages &&
									q_item.read_column < DisplayWidth) ? S_RD : S_DONE;
								ret_q <= S_RDATA;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_WIPE: begin
					// after reset return to idle, after a clear command answer it
					wipe_q <= wipe_q + 1'b1;
					if (wipe_q == (Aw+1)'(Depth - 1)) state_q <= ret_q;
				end
				S_LSETUP: begin
					steep_q <= stp;
					lx_q    <= {1'b0, sax};
					lend_q  <= {1'b0, sbx};
					ly_q    <= say;
					ldx_q   <= {1'b0, sbx - sax};
					ldy_q   <= (sby >= say) ? {1'b0, sby - say} : {1'b0, say - sby};
					err_q   <= $signed({2'b0, sbx - sax} >> 1);
					yneg_q  <= !(say < sby);
					state_q <= S_LINE;
				end
				S_LINE: begin
					if (lx_q > lend_q) begin
						if (it_q.command == CMD_RECT && edge_q != 2'd3) begin
							{lax_q, lay_q, lbx_q, lby_q} <= rect_edge(it_q, edge_q + 2'd1);
							edge_q  <= edge_q + 2'd1;
							state_q <= S_LSETUP;
						end else state_q <= S_DONE;
					end else begin
						px_q <= steep_q ? ly_q : lx_q[7:0];
						py_q <= steep_q ? lx_q[7:0] : ly_q;
						lx_q <= lx_q + 9'd1;
						if (err_q - $signed({1'b0, ldy_q}) < 0) begin
							ly_q  <= yneg_q ? ly_q - 8'd1 : ly_q + 8'd1;
							err_q <= err_q - $signed({1'b0, ldy_q}) + $signed({1'b0, ldx_q});
						end else err_q <= err_q - $signed({1'b0, ldy_q});
						ret_q   <= S_LINE;
						state_q <= S_PIX;
					end
				end
				S_CIRC: begin
					// the x=0 pass plots the four axis points, each twice
					px_q <= cpx; py_q <= cpy;
					ret_q <= S_CIRC;
					state_q <= S_PIX;
					oct_q <= oct_q + 3'd1;
					if (oct_q == 3'd7) begin
						if (!(lx_q[7:0] < ly_q)) ret_q <= S_DONE;
						else begin
							f_q <= f_n; ddy_q <= ddy_n; ddx_q <= ddx_n;
							ly_q <= cy_n; lx_q <= lx_q + 9'd1;
						end
					end
				end
				S_PIX: state_q <= ({1'b0, px_q} < 9'(DisplayWidth) &&
					{1'b0, py_q} < 9'(Rows)) ? S_RD : ret_q;
				S_RD: state_q <= (ret_q == S_RDATA) ? S_RDATA : S_WR;
				S_WR: state_q <= ret_q;
				S_RDATA: begin
					res_q.read_data <= rdata;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!res_v_q || res.ready) begin
						res_v_q <= 1'b1;
						state_q <= S_IDLE;
						ret_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sv/mono_framebuffer_line_circle_drawer_top.sv
`default_nettype none
// 128x64 monochrome framebuffer with pixel, line, circle, rectangle, clear and
// byte-read commands; every command returns one result item (read_data and
// is_read, both zero unless a read). Items queue two deep in front of the
// rasterizer. Each drawn pixel costs a read-modify-write of one frame byte
// through a RAM with one write and one read port, in the states S_PIX, S_RD
// and S_WR. Clear, and the clearing pass after reset, sweep the RAM one byte a
// cycle over all DISPLAY_WIDTH*DISPLAY_PAGES (1024) bytes, during which no
// item leaves the queue.
module mono_framebuffer_line_circle_drawer_top import mfb_pkg::*; #(
	parameter int DISPLAY_WIDTH = DisplayWidthDef,
	parameter int DISPLAY_PAGES = DisplayPagesDef
) (
	input wire logic  clk,
	input wire logic  arst_n,
	mfb_cmd_if.sink   cmd,
	mfb_res_if.source res
);
	logic      q_valid, q_pop;
	cmd_item_t q_item;

	// Front: hold accepted items.
	mfb_front u_front (
		.clk, .arst_n, .cmd, .q_valid, .q_item, .q_pop
	);

	// Back: rasterize and answer.
	mfb_back #(.DisplayWidth(DISPLAY_WIDTH), .DisplayPages(DISPLAY_PAGES)) u_back (
		.clk, .arst_n, .q_valid, .q_item, .q_pop, .res
	);
endmodule
`default_nettype wire

// File: sv/mfb_checker.sv
`default_nettype none
`include "mono_framebuffer_line_circle_drawer_top_defines.svh"
module mfb_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic [7:0] res_read_data,
	input wire logic res_is_read
);
	`MFB_ASSERT_IMPL(a_data_zero, clk, arst_n, res_valid && !res_is_read, res_read_data == 8'd0, "nonread result carries data")
	`MFB_ASSERT_NEXT(a_hold, clk, arst_n, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`MFB_ASSERT_NEXT(a_stable, clk, arst_n, res_valid && !res_ready, $stable(res_read_data), "stalled result changed")
endmodule

bind mono_framebuffer_line_circle_drawer_top mfb_checker u_chk (
	.clk(clk), .arst_n(arst_n), .res_valid(res.valid), .res_ready(res.ready),
	.res_read_data(res.data.read_data), .res_is_read(res.data.is_read)
);
`default_nettype wire
